// ===== hw/rtl/hdm_pkg.sv =====
// Package for the holonomic drive mixer: transaction structs, step counts
// and the back end state type. No dependencies.
package hdm_pkg;

  typedef struct packed {
    logic signed [7:0] forward_axis;
    logic signed [7:0] strafe_axis;
    logic signed [7:0] turn_axis;
  } hdm_cmd_t;

  typedef struct packed {
    logic signed [15:0] front_left_drive;
    logic signed [15:0] back_left_drive;
    logic signed [15:0] front_right_drive;
    logic signed [15:0] back_right_drive;
  } hdm_drive_t;

  // Scaled translation terms (Q16 percent) plus the raw turn reading.
  typedef struct packed {
    logic signed [24:0] p_plus;
    logic signed [24:0] p_minus;
    logic signed [7:0]  turn;
  } hdm_mid_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOAD,
    BK_DIVIDE,
    BK_HOLD
  } hdm_back_state_t;

  // Two quotient bits per cycle: 24 bits in the front, 16 in the back.
  localparam int unsigned FRONT_STEPS = 12;
  localparam int unsigned BACK_STEPS  = 8;

  // 100 percent in Q16.
  localparam logic [24:0] LIM_FLOOR = 25'd6553600;
  localparam logic [6:0]  OUT_PCT   = 7'd100;

endpackage

// ===== hw/rtl/holonomic_drive_mixer.sv =====
// Top level of the holonomic drive mixer: front end, queue, back end.
// Depends on hdm_pkg, hdm_front, hdm_queue and hdm_back.
//
// Usage:
//   Input channel: drive cmd (forward, strafe, turn in percent) and raise
//   push; the transaction is taken on a clock edge with push high and full
//   low. Result channel: while empty is low, drive holds the four wheel
//   commands (percent times 256); raise pop to take the transaction.
//   One result comes out for every input, in order.
// Path with idle stages, from the accepting edge to empty falling: the front
//   divider steps, the hand-off into the queue, the pop into the back end,
//   finding the limit and loading the back divider, the back divider steps,
//   then the output register.
// Pace: set by the front end's two-bit-per-cycle max/sum divider, which
//   takes no new transaction until it has finished the last one; the back
//   end overlaps with it.
//   The front takes a new item the same cycle it hands one to the queue.
// Reset: rst clears the control state; all queues come up empty and
//   empty is high. Payload registers are not reset.
// Stalls: when pop stays low the result holds; the back end then holds
//   its finished item, the queue fills, and finally full rises.
module holonomic_drive_mixer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  hdm_pkg::hdm_cmd_t   cmd,
  output logic                empty,
  input  logic                pop,
  output hdm_pkg::hdm_drive_t drive
);
  import hdm_pkg::*;

  hdm_mid_t front_mid, back_mid;
  logic     front_valid, queue_full;
  logic     back_valid, back_pop;

  // Accept and scale the translation terms.
  hdm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .mid_valid (front_valid),
    .mid_full  (queue_full),
    .mid       (front_mid)
  );

  // Decouple front and back so each can stall on its own.
  hdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_full  (queue_full),
    .wr_data  (front_mid),
    .rd_valid (back_valid),
    .rd_pop   (back_pop),
    .rd_data  (back_mid)
  );

  // Mix in turn, normalize, hold the result for the receiver.
  hdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (back_valid),
    .mid_pop   (back_pop),
    .mid       (back_mid),
    .empty     (empty),
    .pop       (pop),
    .drive     (drive)
  );

endmodule

// ===== hw/rtl/hdm_front.sv =====
// Front end: accepts stick readings, forms the wheel sums and scales them
// by max/sum with a two-bit-per-cycle divider. Uses hdm_pkg.
module hdm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  hdm_pkg::hdm_cmd_t cmd,
  output logic              mid_valid,
  input  logic              mid_full,
  output hdm_pkg::hdm_mid_t mid
);
  import hdm_pkg::*;

  logic              busy;
  logic              done;
  logic [3:0]        cnt;
  logic [8:0]        d;
  logic              zero;
  logic              neg_p, neg_m;
  logic [8:0]        rem_p, rem_m;
  logic [23:0]       lo_p, lo_m;
  logic [23:0]       q_p, q_m;
  logic signed [7:0] turn;

  logic              accept;
  logic              release_mid;
  logic signed [8:0] fx, sx, sum_p, sum_m;
  logic [7:0]        af, as_v, peak;
  logic [8:0]        denom, mag_p, mag_m;
  logic [16:0]       a_p, a_m;
  logic [9:0]        s1p, s2p, s1m, s2m;

  function automatic logic [9:0] step1(input logic [8:0] r, input logic b,
                                       input logic [8:0] dv);
    logic [9:0] t;
    logic [9:0] s;
    t = {r, b};
    s = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return {s[8:0], 1'b1};
    end
    return {t[8:0], 1'b0};
  endfunction

  assign release_mid = done && !mid_full;
  assign full        = busy && !release_mid;
  assign accept      = push && !full;
  assign mid_valid   = done;

  always_comb begin
    fx    = 9'(cmd.forward_axis);
    sx    = 9'(cmd.strafe_axis);
    af    = fx[8] ? 8'(-fx) : fx[7:0];
    as_v  = sx[8] ? 8'(-sx) : sx[7:0];
    denom = {1'b0, af} + {1'b0, as_v};
    peak  = (af > as_v) ? af : as_v;
    sum_p = fx + sx;
    sum_m = fx - sx;
    mag_p = sum_p[8] ? 9'(-sum_p) : sum_p;
    mag_m = sum_m[8] ? 9'(-sum_m) : sum_m;
    a_p   = 17'(mag_p * peak);
    a_m   = 17'(mag_m * peak);
  end

  always_comb begin
    s1p = step1(rem_p, lo_p[23], d);
    s2p = step1(s1p[9:1], lo_p[22], d);
    s1m = step1(rem_m, lo_m[23], d);
    s2m = step1(s1m[9:1], lo_m[22], d);
  end

  always_comb begin
    mid.turn    = turn;
    mid.p_plus  = zero ? '0 : (neg_p ? -$signed({1'b0, q_p}) : $signed({1'b0, q_p}));
    mid.p_minus = zero ? '0 : (neg_m ? -$signed({1'b0, q_m}) : $signed({1'b0, q_m}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (release_mid) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (busy && !done) begin
      cnt <= cnt + 4'd1;
      if (cnt == 4'(FRONT_STEPS - 1)) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d     <= denom;
      zero  <= (denom == '0);
      neg_p <= sum_p[8];
      neg_m <= sum_m[8];
      rem_p <= {1'b0, a_p[15:8]};
      rem_m <= {1'b0, a_m[15:8]};
      lo_p  <= {a_p[7:0], 16'h0};
      lo_m  <= {a_m[7:0], 16'h0};
      q_p   <= '0;
      q_m   <= '0;
      turn  <= cmd.turn_axis;
    end else if (busy && !done) begin
      rem_p <= s2p[9:1];
      rem_m <= s2m[9:1];
      lo_p  <= {lo_p[21:0], 2'b00};
      lo_m  <= {lo_m[21:0], 2'b00};
      q_p   <= {q_p[21:0], s1p[0], s2p[0]};
      q_m   <= {q_m[21:0], s1m[0], s2m[0]};
    end
  end

endmodule

// ===== hw/rtl/hdm_queue.sv =====
// Short queue between front and back end. Uses hdm_pkg for the entry type.
module hdm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_full,
  input  hdm_pkg::hdm_mid_t wr_data,
  output logic              rd_valid,
  input  logic              rd_pop,
  output hdm_pkg::hdm_mid_t rd_data
);
  import hdm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hdm_mid_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_wr, do_rd;

  assign wr_full  = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && !wr_full;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/hdm_back.sv =====
// Back end: adds turn, finds the normalization limit and divides all four
// wheels in parallel, two bits per cycle. Uses hdm_pkg.
module hdm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                mid_valid,
  output logic                mid_pop,
  input  hdm_pkg::hdm_mid_t   mid,
  output logic                empty,
  input  logic                pop,
  output hdm_pkg::hdm_drive_t drive
);
  import hdm_pkg::*;

  hdm_back_state_t    state, state_next;
  logic signed [25:0] v [4];
  logic               neg [4];
  logic [24:0]        rem [4];
  logic [15:0]        lo [4];
  logic [15:0]        q [4];
  logic [24:0]        lim;
  logic [2:0]         cnt;
  logic               out_valid;
  hdm_drive_t         out_reg;

  logic               can_release;
  logic               load_out;
  logic signed [25:0] pp, pm, tq;
  logic [24:0]        mag [4];
  logic [31:0]        prod [4];
  logic [24:0]        lim_calc;
  logic [25:0]        st1 [4];
  logic [25:0]        st2 [4];
  logic signed [15:0] res [4];

  function automatic logic [25:0] step1(input logic [24:0] r, input logic b,
                                        input logic [24:0] dv);
    logic [25:0] t;
    logic [25:0] s;
    t = {r, b};
    s = t - {1'b0, dv};
    if (t >= {1'b0, dv}) begin
      return {s[24:0], 1'b1};
    end
    return {t[24:0], 1'b0};
  endfunction

  assign can_release = !out_valid || pop;
  assign empty       = !out_valid;
  assign drive       = out_reg;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (mid_valid) state_next = BK_LOAD;
      BK_LOAD:   state_next = BK_DIVIDE;
      BK_DIVIDE: if (cnt == 3'(BACK_STEPS - 1)) state_next = BK_HOLD;
      BK_HOLD: begin
        if (can_release) begin
          state_next = mid_valid ? BK_LOAD : BK_IDLE;
        end
      end
      default:   state_next = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    mid_pop  = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: mid_pop = mid_valid;
      BK_HOLD: begin
        load_out = can_release;
        mid_pop  = can_release && mid_valid;
      end
      default: begin
        mid_pop  = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    pp = 26'(mid.p_plus);
    pm = 26'(mid.p_minus);
    tq = {{2{mid.turn[7]}}, mid.turn, 16'h0};
    lim_calc = LIM_FLOOR;
    for (int i = 0; i < 4; i++) begin
      mag[i]  = v[i][25] ? 25'(-v[i]) : v[i][24:0];
      prod[i] = 32'(mag[i] * OUT_PCT);
      if (mag[i] > lim_calc) begin
        lim_calc = mag[i];
      end
      st1[i] = step1(rem[i], lo[i][15], lim);
      st2[i] = step1(st1[i][25:1], lo[i][14], lim);
      res[i] = neg[i] ? -$signed(q[i]) : $signed(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      v[0] <= pp + tq;
      v[1] <= pm + tq;
      v[2] <= pm - tq;
      v[3] <= pp - tq;
    end
    if (state == BK_LOAD) begin
      lim <= lim_calc;
      cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        neg[i] <= v[i][25];
        rem[i] <= {1'b0, prod[i][31:8]};
        lo[i]  <= {prod[i][7:0], 8'h0};
        q[i]   <= '0;
      end
    end else if (state == BK_DIVIDE) begin
      cnt <= cnt + 3'd1;
      for (int i = 0; i < 4; i++) begin
        rem[i] <= st2[i][25:1];
        lo[i]  <= {lo[i][13:0], 2'b00};
        q[i]   <= {q[i][13:0], st1[i][0], st2[i][0]};
      end
    end
    if (load_out) begin
      out_reg.front_left_drive  <= res[0];
      out_reg.back_left_drive   <= res[1];
      out_reg.front_right_drive <= res[2];
      out_reg.back_right_drive  <= res[3];
    end
  end

endmodule

// ===== hw/rtl/hdm_checker.sv =====
// Port-level checks for the holonomic drive mixer, bound to the top level.
// Depends on hdm_pkg and holonomic_drive_mixer.
module hdm_checker (
  input logic                clk,
  input logic                rst,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input hdm_pkg::hdm_drive_t drive
);
  import hdm_pkg::*;

  // Leave reset with nothing to show.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // Leave reset ready to take a transaction.
  a_reset_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // Every wheel command stays within full scale.
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (drive.front_left_drive  >= -16'sd25600 &&
                drive.front_left_drive  <=  16'sd25600 &&
                drive.back_left_drive   >= -16'sd25600 &&
                drive.back_left_drive   <=  16'sd25600 &&
                drive.front_right_drive >= -16'sd25600 &&
                drive.front_right_drive <=  16'sd25600 &&
                drive.back_right_drive  >= -16'sd25600 &&
                drive.back_right_drive  <=  16'sd25600))
    else $error("wheel command out of range");

  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(drive)))
    else $error("result changed while stalled");

endmodule

bind holonomic_drive_mixer hdm_checker u_hdm_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .drive (drive)
);
